// ----- hw/rtl/rpr_pkg.sv -----
package rpr_pkg;

    localparam int CordicStagesDefault = 24;
    localparam int ElementWidthDefault = 24;

    localparam int PosWidth  = 16;
    localparam int FreqWidth = 32;
    localparam int ProdWidth = PosWidth + FreqWidth;   // Q16.32 angle
    localparam int AngWidth  = 36;                     // signed Q.32, |z| < 2^35
    localparam int CsWidth   = 32;                     // signed Q.30 cos/sin

    localparam logic [35:0] TwoPiQ32     = 36'd26986075409;
    localparam logic [35:0] PiQ32        = 36'd13493037705;
    localparam logic [35:0] HalfPiQ32    = 36'd6746518852;
    localparam logic [31:0] QuarterPiQ32 = 32'd3373259426;
    localparam logic [31:0] GainQ30      = 32'd652032874;

    // arctangent of 2^-i in Q.32, series in Q.60 rounded to nearest
    function automatic logic signed [AngWidth-1:0] atan_pow2(input int i);
        longint      acc;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] part;
        int          e;
        int          k;
        int          b;
        acc = 0;
        if (i == 0) begin
            return AngWidth'(longint'(QuarterPiQ32));
        end
        for (k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e < 60) begin
                num  = 64'd1 << (60 - e);
                den  = 64'(2 * k + 1);
                quo  = '0;
                part = '0;
                // restoring long division, one quotient bit at a time
                for (b = 63; b >= 0; b--) begin
                    part = {part[62:0], num[b]};
                    if (part >= den) begin
                        part   = part - den;
                        quo[b] = 1'b1;
                    end
                end
                acc = k[0] ? acc - longint'(quo) : acc + longint'(quo);
            end
        end
        return AngWidth'((acc + (longint'(1) <<< 27)) >>> 28);
    endfunction

endpackage

// ----- hw/rtl/rotary_position_rotate.sv -----
// Channel  | Ports                                                   | Direction
// ---------+---------------------------------------------------------+----------
// input    | s_valid s_ready s_even_value s_odd_value s_position     | in
//          | s_inverse_frequency s_last_pair                         |
// result   | m_valid m_ready m_rotated_even m_rotated_odd m_last_out | out
//
// One item per cycle sustained while m_ready does not stall. Pipeline stages in
// order: multiply stage, serial modulo two pi one quotient bit a stage over 14
// stages, fold, CORDIC one stage per iteration, sign correction, product, round/saturate.
// aresetn clears valid bits only. A stall at m_ready freezes the whole pipeline
// in place (global enable); the output register holds its item and s_ready
// drops with it.
module rotary_position_rotate
    import rpr_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDefault,
    parameter int ELEMENT_WIDTH = ElementWidthDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [ELEMENT_WIDTH-1:0] s_even_value,
    input  logic signed [ELEMENT_WIDTH-1:0] s_odd_value,
    input  logic [PosWidth-1:0]             s_position,
    input  logic [FreqWidth-1:0]            s_inverse_frequency,
    input  logic                            s_last_pair,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ELEMENT_WIDTH-1:0] m_rotated_even,
    output logic signed [ELEMENT_WIDTH-1:0] m_rotated_odd,
    output logic                            m_last_out
);

    localparam int ModSteps  = 14;   // product < 2^48, two pi > 2^34
    localparam int RemWidth  = 36;
    localparam int ProdW     = ELEMENT_WIDTH + CsWidth;
    localparam int SumW      = ProdW + 1;

    typedef struct packed {
        logic signed [ELEMENT_WIDTH-1:0] ev;
        logic signed [ELEMENT_WIDTH-1:0] od;
        logic                            last;
    } side_t;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 0: angle product
    logic              v0_reg;
    side_t             sd0_reg;
    logic [ProdWidth-1:0] prod_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
        if (en) begin
            sd0_reg  <= '{ev: s_even_value, od: s_odd_value, last: s_last_pair};
            prod_reg <= s_position * s_inverse_frequency;
        end
    end

    // Restoring remainder by two pi, one quotient bit per stage (high bit first)
    logic                 mv_reg  [ModSteps];
    side_t                msd_reg [ModSteps];
    logic [ProdWidth-1:0] mr_reg  [ModSteps];
    genvar g;
    generate
        for (g = 0; g < ModSteps; g++) begin : g_mod
            localparam int Sh = ModSteps - 1 - g;
            logic [ProdWidth-1:0] r_in;
            logic [ProdWidth-1:0] dv;
            logic                 vin;
            side_t                sin_d;
            if (g == 0) begin : g_first
                assign r_in  = prod_reg;
                assign vin   = v0_reg;
                assign sin_d = sd0_reg;
            end else begin : g_rest
                assign r_in  = mr_reg[g-1];
                assign vin   = mv_reg[g-1];
                assign sin_d = msd_reg[g-1];
            end
            assign dv = ProdWidth'(TwoPiQ32) << Sh;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    mv_reg[g] <= 1'b0;
                end else if (en) begin
                    mv_reg[g] <= vin;
                end
                if (en) begin
                    msd_reg[g] <= sin_d;
                    mr_reg[g]  <= (r_in >= dv) ? r_in - dv : r_in;
                end
            end
        end
    endgenerate

    // Fold into [-pi/2, pi/2]
    logic [RemWidth-1:0]       rem;
    logic signed [AngWidth:0]  zc;
    logic signed [AngWidth:0]  zf;
    logic                      neg_f;
    always_comb begin
        rem   = mr_reg[ModSteps-1][RemWidth-1:0];
        zc    = (rem > PiQ32) ? $signed({1'b0, rem}) - $signed({1'b0, TwoPiQ32})
                              : $signed({1'b0, rem});
        zf    = zc;
        neg_f = 1'b0;
        if (zc > $signed({1'b0, HalfPiQ32})) begin
            zf    = zc - $signed({1'b0, PiQ32});
            neg_f = 1'b1;
        end else if (zc < -$signed({1'b0, HalfPiQ32})) begin
            zf    = zc + $signed({1'b0, PiQ32});
            neg_f = 1'b1;
        end
    end

    logic                        vf_reg;
    side_t                       sdf_reg;
    logic                        negf_reg;
    logic signed [AngWidth-1:0]  zf_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= mv_reg[ModSteps-1];
        end
        if (en) begin
            sdf_reg  <= msd_reg[ModSteps-1];
            negf_reg <= neg_f;
            zf_reg   <= zf[AngWidth-1:0];
        end
    end

    // CORDIC rotation, one iteration per stage
    logic                       cv_reg  [CORDIC_STAGES];
    side_t                      csd_reg [CORDIC_STAGES];
    logic                       cn_reg  [CORDIC_STAGES];
    logic signed [CsWidth:0]    cx_reg  [CORDIC_STAGES];
    logic signed [CsWidth:0]    cy_reg  [CORDIC_STAGES];
    logic signed [AngWidth-1:0] cz_reg  [CORDIC_STAGES];
    generate
        for (g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
            localparam logic signed [AngWidth-1:0] Atan = atan_pow2(g);
            logic signed [CsWidth:0]    xi;
            logic signed [CsWidth:0]    yi;
            logic signed [AngWidth-1:0] zi;
            logic signed [CsWidth:0]    dx;
            logic signed [CsWidth:0]    dy;
            logic                       vin;
            side_t                      sin_d;
            logic                       nin;
            if (g == 0) begin : g_first
                assign xi    = $signed({1'b0, GainQ30});
                assign yi    = '0;
                assign zi    = zf_reg;
                assign vin   = vf_reg;
                assign sin_d = sdf_reg;
                assign nin   = negf_reg;
            end else begin : g_rest
                assign xi    = cx_reg[g-1];
                assign yi    = cy_reg[g-1];
                assign zi    = cz_reg[g-1];
                assign vin   = cv_reg[g-1];
                assign sin_d = csd_reg[g-1];
                assign nin   = cn_reg[g-1];
            end
            assign dx = yi >>> g;
            assign dy = xi >>> g;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cv_reg[g] <= 1'b0;
                end else if (en) begin
                    cv_reg[g] <= vin;
                end
                if (en) begin
                    csd_reg[g] <= sin_d;
                    cn_reg[g]  <= nin;
                    if (!zi[AngWidth-1]) begin
                        cx_reg[g] <= xi - dx;
                        cy_reg[g] <= yi + dy;
                        cz_reg[g] <= zi - Atan;
                    end else begin
                        cx_reg[g] <= xi + dx;
                        cy_reg[g] <= yi - dy;
                        cz_reg[g] <= zi + Atan;
                    end
                end
            end
        end
    endgenerate

    // Sign correction
    localparam int Lc = CORDIC_STAGES - 1;
    logic                    sv_reg;
    side_t                   ssd_reg;
    logic signed [CsWidth:0] cos_reg;
    logic signed [CsWidth:0] sin_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= 1'b0;
        end else if (en) begin
            sv_reg <= cv_reg[Lc];
        end
        if (en) begin
            ssd_reg <= csd_reg[Lc];
            cos_reg <= cn_reg[Lc] ? -cx_reg[Lc] : cx_reg[Lc];
            sin_reg <= cn_reg[Lc] ? -cy_reg[Lc] : cy_reg[Lc];
        end
    end

    // Four products, registered
    logic                     pv_reg;
    logic                     plast_reg;
    logic signed [ProdW:0]    pec_reg, pos_reg, pes_reg, poc_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= sv_reg;
        end
        if (en) begin
            plast_reg <= ssd_reg.last;
            pec_reg   <= ssd_reg.ev * cos_reg;
            pos_reg   <= ssd_reg.od * sin_reg;
            pes_reg   <= ssd_reg.ev * sin_reg;
            poc_reg   <= ssd_reg.od * cos_reg;
        end
    end

    // Sum, round half up, saturate
    localparam logic signed [SumW:0] Half  = (SumW+1)'(1) <<< 29;
    localparam logic signed [SumW:0] MaxEl = (SumW+1)'((64'd1 << (ELEMENT_WIDTH-1)) - 1);
    localparam logic signed [SumW:0] MinEl = -MaxEl - 1;
    logic signed [SumW:0] se, so;
    always_comb begin
        se = ((SumW+1)'(pec_reg) - (SumW+1)'(pos_reg) + Half) >>> 30;
        so = ((SumW+1)'(pes_reg) + (SumW+1)'(poc_reg) + Half) >>> 30;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= pv_reg;
        end
        if (en) begin
            m_last_out     <= plast_reg;
            m_rotated_even <= (se > MaxEl) ? MaxEl[ELEMENT_WIDTH-1:0] :
                              (se < MinEl) ? MinEl[ELEMENT_WIDTH-1:0] :
                              se[ELEMENT_WIDTH-1:0];
            m_rotated_odd  <= (so > MaxEl) ? MaxEl[ELEMENT_WIDTH-1:0] :
                              (so < MinEl) ? MinEl[ELEMENT_WIDTH-1:0] :
                              so[ELEMENT_WIDTH-1:0];
        end
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import rpr_pkg::*;

    localparam int Stages  = 24;
    localparam int ElemW   = 24;
    localparam int Latency = Stages + 19;
    localparam int WatchdogLimit = 20000;
    localparam int RandomItems   = 1850;

    localparam longint TwoPi   = 64'd26986075409;
    localparam longint Pi      = 64'd13493037705;
    localparam longint HalfPi  = 64'd6746518852;
    localparam longint Gain    = 64'd652032874;

    typedef struct packed {
        logic signed [ElemW-1:0] rot_even;
        logic signed [ElemW-1:0] rot_odd;
        logic                    last;
    } rotated_pair_t;

    // arctangent of 2^-i in Q.32 by series in Q.60
    function automatic longint arctan_step(input int i);
        longint acc;
        longint term;
        int     e;
        acc = 0;
        if (i == 0) return 64'd3373259426;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e < 60) begin
                term = longint'((64'd1 << (60 - e)) / (2 * k + 1));
                acc = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        return (acc + (longint'(1) <<< 27)) >>> 28;
    endfunction

    function automatic longint clamp_elem(input longint v);
        longint hi;
        hi = (longint'(1) <<< (ElemW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // rotate one pair by position * inverse frequency
    function automatic rotated_pair_t rotate_pair(input logic signed [ElemW-1:0] ev,
            input logic signed [ElemW-1:0] od, input logic [15:0] pos,
            input logic [31:0] freq, input logic last);
        rotated_pair_t r;
        longint z, x, y, dx, dy, c, s, e, o;
        logic [63:0] prod;
        bit flip;
        prod = {48'd0, pos} * {32'd0, freq};
        z = longint'(prod % 64'(TwoPi));
        flip = 0;
        if (z > Pi) z -= TwoPi;
        if (z > HalfPi) begin
            z -= Pi;
            flip = 1;
        end else if (z < -HalfPi) begin
            z += Pi;
            flip = 1;
        end
        x = Gain;
        y = 0;
        for (int i = 0; i < Stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        e = ev;
        o = od;
        r.rot_even = ElemW'(clamp_elem((e * c - o * s + (longint'(1) <<< 29)) >>> 30));
        r.rot_odd  = ElemW'(clamp_elem((e * s + o * c + (longint'(1) <<< 29)) >>> 30));
        r.last = last;
        return r;
    endfunction

    class rotation_scoreboard;
        rotated_pair_t pending[$];
        int mismatches = 0;
        int checked = 0;

        function void note_input(input rotated_pair_t exp_pair);
            pending.push_back(exp_pair);
        endfunction

        function void check_result(input rotated_pair_t got);
            rotated_pair_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected e=%0d o=%0d l=%0d got e=%0d o=%0d l=%0d",
                             want.rot_even, want.rot_odd, want.last,
                             got.rot_even, got.rot_odd, got.last);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [ElemW-1:0] s_even_value = '0;
    logic signed [ElemW-1:0] s_odd_value = '0;
    logic [15:0] s_position = '0;
    logic [31:0] s_inverse_frequency = '0;
    logic s_last_pair = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [ElemW-1:0] m_rotated_even;
    logic signed [ElemW-1:0] m_rotated_odd;
    logic m_last_out;

    rotation_scoreboard board = new();
    bit quiet_phase = 0;
    bit hold_off = 0;
    bit stim_done = 0;
    int idle_cycles = 0;

    always #1 aclk = ~aclk;

    rotary_position_rotate #(.CORDIC_STAGES(Stages), .ELEMENT_WIDTH(ElemW)) DUT (.*);

    // scoreboard and watchdog sample at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_input(rotate_pair(s_even_value, s_odd_value, s_position,
                                             s_inverse_frequency, s_last_pair));
            if (m_valid && m_ready)
                board.check_result('{m_rotated_even, m_rotated_odd, m_last_out});
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off
    initial begin
        int gap;
        @(posedge aclk);
        while (1) begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 7);
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    // offer one item and hold it until accepted
    task automatic send_pair(input logic [ElemW-1:0] ev, input logic [ElemW-1:0] od,
            input logic [15:0] pos, input logic [31:0] freq, input logic last);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_even_value <= ev;
        s_odd_value <= od;
        s_position <= pos;
        s_inverse_frequency <= freq;
        s_last_pair <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random(input int n);
        logic [ElemW-1:0] ev, od;
        logic [31:0] freq;
        for (int i = 0; i < n; i++) begin
            ev = ElemW'($urandom);
            od = ElemW'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                ev = ElemW'($urandom_range(0, 1000));
                od = ev ^ {ElemW{$urandom_range(0, 1) == 1}};
            end
            case ($urandom_range(0, 3))
                0: freq = $urandom >> $urandom_range(0, 31);
                default: freq = $urandom;
            endcase
            send_pair(ev, od, 16'($urandom_range(0, 65535) >> $urandom_range(0, 15)),
                      freq, (i % 8) == 7);
        end
    endtask

    initial begin
        localparam logic [ElemW-1:0] MaxE = {1'b0, {(ElemW-1){1'b1}}};
        localparam logic [ElemW-1:0] MinE = {1'b1, {(ElemW-1){1'b0}}};
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, zero angle, saturation, quadrant folds
        send_pair(MaxE, MaxE, 16'd0, 32'd0, 0);
        send_pair(MinE, MinE, 16'd1, 32'd0, 1);
        send_pair(MaxE, MinE, 16'd0, 32'hFFFFFFFF, 0);
        send_pair(MaxE, MaxE, 16'd1, 32'd3373259426, 0);
        send_pair(MinE, MinE, 16'd1, 32'd3373259426, 1);
        send_pair(MaxE, MinE, 16'hFFFF, 32'hFFFFFFFF, 0);
        send_pair(24'd65536, 24'd0, 16'd2, 32'hFFFFFFFF, 0);
        send_pair(24'd65536, 24'd0, 16'd3, 32'hFFFFFFFF, 0);
        send_pair(24'd65536, 24'd65536, 16'd4, 32'hC0000000, 1);
        send_pair(24'hFFFFFF, 24'd1, 16'd5, 32'h80000000, 0);
        send_pair(24'd0, MaxE, 16'd7, 32'hF0000000, 0);
        send_pair(MinE, 24'd0, 16'hFFFF, 32'd1, 1);
        send_pair(24'h555555, 24'hAAAAAA, 16'h5555, 32'hAAAAAAAA, 0);
        send_pair(24'hAAAAAA, 24'h555555, 16'hAAAA, 32'h55555555, 1);

        send_random(600);
        hold_off = 1;
        send_random(400);
        send_random(650);
        quiet_phase = 1;
        send_random(200);
        s_valid <= 0;
        stim_done = 1;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (Latency + 10) @(posedge aclk);
        $display("Checked %0d rotated pairs over random angles, saturating values and",
                 board.checked);
        $display("stall patterns including a long output hold-off; %0d mismatches.",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
